FILE: src/dbwc_pkg.sv
// Package for the delay-based window controller.
// Holds the sequencer state type, the arithmetic unit status type and the fixed constants.
// No dependencies.
package dbwc_pkg;

  // Widths of the configuration channel.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 40;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_TARGET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADD_INC      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEC_BETA     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEC_FRAC = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_RANGE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_MIN_WIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_ALPHA   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_BETA    = 3'd7;

  // Event codes.
  localparam logic OP_ACK     = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  // Fixed-point one packet and saturation value.
  localparam logic [31:0] ONE_Q16 = 32'd65536;
  localparam logic [31:0] SAT32   = 32'hFFFF_FFFF;

  // Reset values of the configuration registers.
  localparam logic [31:0] RST_BASE_TARGET  = 32'd25000;
  localparam logic [19:0] RST_ADD_INC      = 20'd65536;
  localparam logic [16:0] RST_DEC_BETA     = 17'd52429;
  localparam logic [15:0] RST_MAX_DEC_FRAC = 16'd32768;
  localparam logic [31:0] RST_FLOW_RANGE   = 32'd100000;
  localparam logic [31:0] RST_FLOW_MIN_WIN = 32'd6554;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQRT,
    ST_SQRT_WAIT,
    ST_FDIV_WAIT,
    ST_TGT,
    ST_DECIDE,
    ST_INC_WAIT,
    ST_OVER_WAIT,
    ST_GAIN,
    ST_CUT,
    ST_SCALE,
    ST_SET,
    ST_PACE,
    ST_PACE_WAIT,
    ST_OUT
  } dbwc_state_e;

  // Status of an iterative arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } dbwc_unit_stat_t;

endpackage

FILE: src/dbwc_evt_if.sv
// Event channel interface of the delay-based window controller.
// Carries one event word; no dependencies.
interface dbwc_evt_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] rtt_ns;
  logic [47:0] now_ns;

  modport source (output valid, output opcode, output rtt_ns, output now_ns, input ready);
  modport sink   (input valid, input opcode, input rtt_ns, input now_ns, output ready);
endinterface

FILE: src/dbwc_res_if.sv
// Result channel interface of the delay-based window controller.
// Carries one result word; no dependencies.
interface dbwc_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] window;
  logic [31:0] send_window;
  logic [31:0] pacing_delay_ns;
  logic [31:0] target_delay_ns;
  logic        bad_rtt;

  modport source (output valid, output window, output send_window, output pacing_delay_ns,
                  output target_delay_ns, output bad_rtt, input ready);
  modport sink   (input valid, input window, input send_window, input pacing_delay_ns,
                  input target_delay_ns, input bad_rtt, output ready);
endinterface

FILE: src/dbwc_cfg_if.sv
// Configuration write channel interface of the delay-based window controller.
// Depends on dbwc_pkg for the index and data widths.
interface dbwc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [dbwc_pkg::CFG_IDX_W-1:0]  index;
  logic [dbwc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/dbwc_div.sv
// Shared restoring divider: 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
// Depends on dbwc_pkg for the unit status type.
module dbwc_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [63:0]             dividend_i,
  input  logic [31:0]             divisor_i,
  output logic [63:0]             quotient_o,
  output dbwc_pkg::dbwc_unit_stat_t stat_o
);

  logic [63:0] dvd_q;
  logic [31:0] rem_q;
  logic [31:0] dsr_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [32:0] rem_sh;
  logic        fits;
  logic [31:0] rem_nx;

  // One restoring step: shift in the next dividend bit and try the subtraction.
  always_comb begin
    rem_sh = {rem_q, dvd_q[63]};
    fits   = rem_sh >= {1'b0, dsr_q};
    rem_nx = fits ? 32'(rem_sh - {1'b0, dsr_q}) : rem_sh[31:0];
  end

  // Step counter and status.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd63;
      end else if (busy_q) begin
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 6'd1;
        end
      end
    end
  end

  // Datapath: the dividend register fills with quotient bits from the right.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[62:0], fits};
      rem_q <= rem_nx;
    end
  end

  assign quotient_o  = dvd_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

FILE: src/dbwc_sqrt.sv
// Integer square root of a 48-bit value, one result bit per cycle.
// Depends on dbwc_pkg for the unit status type.
module dbwc_sqrt (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [47:0]             value_i,
  output logic [23:0]             root_o,
  output dbwc_pkg::dbwc_unit_stat_t stat_o
);

  logic [47:0] v_q;
  logic [47:0] r_q;
  logic [47:0] bit_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [47:0] trial;
  logic        fits;

  // Trial subtraction of the current partial root plus the probe bit.
  always_comb begin
    trial = r_q + bit_q;
    fits  = v_q >= trial;
  end

  // Step counter and status.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd23;
      end else if (busy_q) begin
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 5'd1;
        end
      end
    end
  end

  // Datapath: the probe bit walks down two places a step.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= value_i;
      r_q   <= '0;
      bit_q <= 48'h4000_0000_0000;
    end else if (busy_q) begin
      if (fits) begin
        v_q <= v_q - trial;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign root_o      = r_q[23:0];
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

FILE: src/delay_based_window_controller.sv
// Top level of the delay-based window controller: sequencer, state and configuration.
// Depends on dbwc_pkg, the three channel interfaces, dbwc_div and dbwc_sqrt.
//
//   Channel | Direction | Word
//   evt_i   | in        | opcode, rtt_ns, now_ns
//   res_o   | out       | window, send_window, pacing_delay_ns, target_delay_ns, bad_rtt
//   cfg_i   | in        | index, data (always ready)
//
// The target delay is worked out twice, each time a root and, unless the root is zero, a
// divide; up to two more divides follow for the increase or overshoot and for the pacing
// gap, all on the one shared divider.
// One event is in flight at a time; evt_i is ready only when the sequencer is idle.
// The result word is held until res_o is taken. Reset is asynchronous and active low.
module delay_based_window_controller #(
  parameter logic [16:0] MIN_WINDOW_Q16    = 17'd655,
  parameter logic [31:0] MAX_WINDOW_Q16    = 32'd67108864,
  parameter logic [7:0]  RETRY_RESET_LIMIT = 8'd5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  dbwc_evt_if.sink          evt_i,
  dbwc_res_if.source        res_o,
  dbwc_cfg_if.sink          cfg_i
);

  // Configuration registers.
  logic [31:0] base_q;
  logic [19:0] ai_q;
  logic [16:0] beta_q;
  logic [15:0] mdf_q;
  logic [31:0] range_q;
  logic [31:0] fmw_q;
  logic [39:0] alpha_q;
  logic [39:0] fbeta_q;

  // Controller state.
  logic [31:0] cwnd_q;
  logic [47:0] last_cut_q;
  logic [31:0] last_rtt_q;
  logic [7:0]  retry_q;

  // Per-event working registers.
  dbwc_pkg::dbwc_state_e state_q, state_d;
  logic        op_q;
  logic [31:0] rtt_q;
  logic [47:0] now_q;
  logic        bad_q;
  logic        post_q;
  logic [47:0] term_q;
  logic [32:0] tgt_q;
  logic [32:0] w_q;
  logic [48:0] prod_q;
  logic [16:0] fac_q;
  logic [31:0] pace_q;

  // Shared units.
  logic                      div_start;
  logic [63:0]               div_dvd;
  logic [31:0]               div_dsr;
  logic [63:0]               div_quo;
  dbwc_pkg::dbwc_unit_stat_t div_stat;
  logic                      sq_start;
  logic [47:0]               sq_val;
  logic [23:0]               sq_root;
  dbwc_pkg::dbwc_unit_stat_t sq_stat;

  // Combinational helpers.
  logic [31:0] floor_win;
  logic        rtt_zero;
  logic        below_tgt;
  logic [31:0] cut_rtt;
  logic        may_cut;
  logic [7:0]  retry_nx;
  logic [55:0] f8;
  logic [47:0] term_nx;
  logic [31:0] term_cl;
  logic [16:0] gain;
  logic [16:0] fac_nx;
  logic [31:0] w_clamp;

  dbwc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .quotient_o (div_quo),
    .stat_o     (div_stat)
  );

  dbwc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (sq_val),
    .root_o  (sq_root),
    .stat_o  (sq_stat)
  );

  // Arithmetic shared by several states.
  always_comb begin
    floor_win = (fmw_q > cwnd_q) ? fmw_q : cwnd_q;
    rtt_zero  = (rtt_q == 32'd0);
    below_tgt = {1'b0, rtt_q} < tgt_q;
    cut_rtt   = (op_q == dbwc_pkg::OP_ACK) ? rtt_q : last_rtt_q;
    may_cut   = {1'b0, now_q} > ({1'b0, last_cut_q} + {17'd0, cut_rtt});
    retry_nx  = (retry_q == 8'hFF) ? retry_q : retry_q + 8'd1;
    f8        = div_quo[55:0];
    term_nx   = (f8 > {16'd0, fbeta_q}) ? 48'((f8 - {16'd0, fbeta_q}) >> 8) : 48'd0;
    term_cl   = (term_q > {16'd0, range_q}) ? range_q : term_q[31:0];
    gain      = prod_q[32:16];
    fac_nx    = (gain < {1'b0, mdf_q}) ? 17'(18'h10000 - {1'b0, gain})
                                       : 17'(18'h10000 - {2'b0, mdf_q});
    if (w_q < {16'd0, MIN_WINDOW_Q16}) begin
      w_clamp = {15'd0, MIN_WINDOW_Q16};
    end else if (w_q > {1'b0, MAX_WINDOW_Q16}) begin
      w_clamp = MAX_WINDOW_Q16;
    end else begin
      w_clamp = w_q[31:0];
    end
  end

  // Sequencer: next state and unit requests.
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_dvd   = {8'd0, alpha_q, 16'd0};
    div_dsr   = {8'd0, sq_root};
    sq_start  = 1'b0;
    sq_val    = {floor_win, 16'd0};
    case (state_q)
      dbwc_pkg::ST_IDLE: begin
        if (evt_i.valid) begin
          state_d = dbwc_pkg::ST_SQRT;
        end
      end
      dbwc_pkg::ST_SQRT: begin
        sq_start = 1'b1;
        state_d  = dbwc_pkg::ST_SQRT_WAIT;
      end
      dbwc_pkg::ST_SQRT_WAIT: begin
        if (sq_stat.done) begin
          if (sq_root == 24'd0) begin
            state_d = dbwc_pkg::ST_TGT;
          end else begin
            div_start = 1'b1;
            state_d   = dbwc_pkg::ST_FDIV_WAIT;
          end
        end
      end
      dbwc_pkg::ST_FDIV_WAIT: begin
        if (div_stat.done) begin
          state_d = dbwc_pkg::ST_TGT;
        end
      end
      dbwc_pkg::ST_TGT: begin
        state_d = post_q ? dbwc_pkg::ST_OUT : dbwc_pkg::ST_DECIDE;
      end
      dbwc_pkg::ST_DECIDE: begin
        if (op_q == dbwc_pkg::OP_ACK) begin
          if (rtt_zero) begin
            state_d = dbwc_pkg::ST_PACE;
          end else if (below_tgt) begin
            if (cwnd_q > dbwc_pkg::ONE_Q16) begin
              div_dvd   = {28'd0, ai_q, 16'd0};
              div_dsr   = cwnd_q;
              div_start = 1'b1;
              state_d   = dbwc_pkg::ST_INC_WAIT;
            end else begin
              state_d = dbwc_pkg::ST_SET;
            end
          end else if (may_cut) begin
            div_dvd   = {16'd0, 32'(rtt_q - tgt_q[31:0]), 16'd0};
            div_dsr   = rtt_q;
            div_start = 1'b1;
            state_d   = dbwc_pkg::ST_OVER_WAIT;
          end else begin
            state_d = dbwc_pkg::ST_SET;
          end
        end else begin
          if (retry_nx >= RETRY_RESET_LIMIT || !may_cut) begin
            state_d = dbwc_pkg::ST_SET;
          end else begin
            state_d = dbwc_pkg::ST_CUT;
          end
        end
      end
      dbwc_pkg::ST_INC_WAIT: begin
        if (div_stat.done) begin
          state_d = dbwc_pkg::ST_SET;
        end
      end
      dbwc_pkg::ST_OVER_WAIT: begin
        if (div_stat.done) begin
          state_d = dbwc_pkg::ST_GAIN;
        end
      end
      dbwc_pkg::ST_GAIN: begin
        state_d = dbwc_pkg::ST_CUT;
      end
      dbwc_pkg::ST_CUT: begin
        state_d = dbwc_pkg::ST_SCALE;
      end
      dbwc_pkg::ST_SCALE: begin
        state_d = dbwc_pkg::ST_SET;
      end
      dbwc_pkg::ST_SET: begin
        state_d = dbwc_pkg::ST_PACE;
      end
      dbwc_pkg::ST_PACE: begin
        if (cwnd_q > dbwc_pkg::ONE_Q16 || floor_win == 32'd0) begin
          state_d = dbwc_pkg::ST_SQRT;
        end else begin
          div_dvd   = {16'd0, last_rtt_q, 16'd0};
          div_dsr   = floor_win;
          div_start = 1'b1;
          state_d   = dbwc_pkg::ST_PACE_WAIT;
        end
      end
      dbwc_pkg::ST_PACE_WAIT: begin
        if (div_stat.done) begin
          state_d = dbwc_pkg::ST_SQRT;
        end
      end
      dbwc_pkg::ST_OUT: begin
        if (res_o.ready) begin
          state_d = dbwc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dbwc_pkg::ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dbwc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers and controller state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= dbwc_pkg::RST_BASE_TARGET;
      ai_q       <= dbwc_pkg::RST_ADD_INC;
      beta_q     <= dbwc_pkg::RST_DEC_BETA;
      mdf_q      <= dbwc_pkg::RST_MAX_DEC_FRAC;
      range_q    <= dbwc_pkg::RST_FLOW_RANGE;
      fmw_q      <= dbwc_pkg::RST_FLOW_MIN_WIN;
      alpha_q    <= '0;
      fbeta_q    <= '0;
      cwnd_q     <= dbwc_pkg::ONE_Q16;
      last_cut_q <= '0;
      last_rtt_q <= dbwc_pkg::RST_BASE_TARGET;
      retry_q    <= '0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          dbwc_pkg::CFG_BASE_TARGET:  base_q  <= cfg_i.data[31:0];
          dbwc_pkg::CFG_ADD_INC:      ai_q    <= cfg_i.data[19:0];
          dbwc_pkg::CFG_DEC_BETA:     beta_q  <= cfg_i.data[16:0];
          dbwc_pkg::CFG_MAX_DEC_FRAC: mdf_q   <= cfg_i.data[15:0];
          dbwc_pkg::CFG_FLOW_RANGE:   range_q <= cfg_i.data[31:0];
          dbwc_pkg::CFG_FLOW_MIN_WIN: fmw_q   <= cfg_i.data[31:0];
          dbwc_pkg::CFG_FLOW_ALPHA:   alpha_q <= cfg_i.data;
          dbwc_pkg::CFG_FLOW_BETA:    fbeta_q <= cfg_i.data;
          default: begin
          end
        endcase
      end
      // A valid acknowledgement clears the retries and records its RTT; a timeout adds a retry, saturating at 255.
      if (state_q == dbwc_pkg::ST_DECIDE) begin
        if (op_q == dbwc_pkg::OP_ACK) begin
          if (!rtt_zero) begin
            retry_q    <= '0;
            last_rtt_q <= rtt_q;
          end
        end else begin
          retry_q <= retry_nx;
        end
      end
      // Commit the clamped window; a smaller window marks the time of the cut.
      if (state_q == dbwc_pkg::ST_SET) begin
        cwnd_q <= w_clamp;
        if (w_clamp < cwnd_q) begin
          last_cut_q <= now_q;
        end
      end
    end
  end

  // Per-event datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      dbwc_pkg::ST_IDLE: begin
        op_q   <= evt_i.opcode;
        rtt_q  <= evt_i.rtt_ns;
        now_q  <= evt_i.now_ns;
        bad_q  <= 1'b0;
        post_q <= 1'b0;
        pace_q <= '0;
      end
      dbwc_pkg::ST_SQRT_WAIT: begin
        // A zero root takes the full flow range.
        term_q <= {16'd0, range_q};
      end
      dbwc_pkg::ST_FDIV_WAIT: begin
        if (div_stat.done) begin
          term_q <= term_nx;
        end
      end
      dbwc_pkg::ST_TGT: begin
        tgt_q <= {1'b0, base_q} + {1'b0, term_cl};
      end
      dbwc_pkg::ST_DECIDE: begin
        w_q   <= {1'b0, cwnd_q};
        fac_q <= 17'(18'h10000 - {2'b0, mdf_q});
        if (op_q == dbwc_pkg::OP_ACK) begin
          if (rtt_zero) begin
            bad_q <= 1'b1;
          end else if (below_tgt) begin
            w_q <= {1'b0, cwnd_q} + {13'd0, ai_q};
          end
        end else if (retry_nx >= RETRY_RESET_LIMIT) begin
          w_q <= {16'd0, MIN_WINDOW_Q16};
        end
      end
      dbwc_pkg::ST_INC_WAIT: begin
        w_q <= {1'b0, cwnd_q} + {1'b0, div_quo[31:0]};
      end
      dbwc_pkg::ST_OVER_WAIT: begin
        prod_q <= 49'(beta_q) * 49'(div_quo[16:0]);
      end
      dbwc_pkg::ST_GAIN: begin
        fac_q <= fac_nx;
      end
      dbwc_pkg::ST_CUT: begin
        prod_q <= 49'(cwnd_q) * 49'(fac_q);
      end
      dbwc_pkg::ST_SCALE: begin
        w_q <= prod_q[48:16];
      end
      dbwc_pkg::ST_PACE: begin
        post_q <= 1'b1;
        if (cwnd_q <= dbwc_pkg::ONE_Q16 && floor_win == 32'd0) begin
          pace_q <= dbwc_pkg::SAT32;
        end
      end
      dbwc_pkg::ST_PACE_WAIT: begin
        pace_q <= (div_quo[63:32] != 32'd0) ? dbwc_pkg::SAT32 : div_quo[31:0];
      end
      default: begin
      end
    endcase
  end

  // Channel outputs.
  assign evt_i.ready           = (state_q == dbwc_pkg::ST_IDLE);
  assign cfg_i.ready           = 1'b1;
  assign res_o.valid           = (state_q == dbwc_pkg::ST_OUT);
  assign res_o.window          = cwnd_q;
  assign res_o.send_window     = (cwnd_q > dbwc_pkg::ONE_Q16) ? cwnd_q : dbwc_pkg::ONE_Q16;
  assign res_o.pacing_delay_ns = pace_q;
  assign res_o.target_delay_ns = tgt_q[32] ? dbwc_pkg::SAT32 : tgt_q[31:0];
  assign res_o.bad_rtt         = bad_q;

`ifndef SYNTH
  // The window always stays inside its clamp range.
  a_cwnd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cwnd_q >= {15'd0, MIN_WINDOW_Q16}) && (cwnd_q <= MAX_WINDOW_Q16))
    else $error("window left its clamp range");

  // No new event is taken while a result word is offered.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(evt_i.ready && res_o.valid))
    else $error("event accepted while a result is pending");

  // The shared divider is never restarted mid-operation.
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // The root unit is never restarted mid-operation.
  a_sqrt_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_start |-> !sq_stat.busy)
    else $error("square root unit started while busy");
`endif

endmodule
